// ----- rtl/vn3d_pkg.sv -----
// ----------------------------------------------------------------------------
// vn3d_pkg
// Shared types and fixed output widths for the 3d vector normalizer.
// ----------------------------------------------------------------------------
package vn3d_pkg;

    localparam int UNIT_W = 16;
    localparam int MAG_W  = 16;

    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } t_flags;

endpackage

// ----- rtl/vector_normalize_3d_top.sv -----
// ----------------------------------------------------------------------------
// vector_normalize_3d_top
// Normalizes a signed 3d vector to Q1.FB unit components plus its length.
// ----------------------------------------------------------------------------
// One beat is taken every cycle while o_stall is low. After three stages
// for sign removal, squaring and summing, a row of COMPONENT_WIDTH
// square-root cells settles one root bit each, then a row of
// UNIT_FRACTION_BITS + 1 divider cells settles one quotient bit of all three
// components each. The whole row holds while the output beat is stalled.
// A zero vector gives zero_vector set and all other fields zero.
module vector_normalize_3d_top #(
    parameter int COMPONENT_WIDTH    = 16,
    parameter int UNIT_FRACTION_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_x_in,
    input  logic signed [COMPONENT_WIDTH-1:0] i_y_in,
    input  logic signed [COMPONENT_WIDTH-1:0] i_z_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [vn3d_pkg::UNIT_W-1:0] o_x_unit,
    output logic signed [vn3d_pkg::UNIT_W-1:0] o_y_unit,
    output logic signed [vn3d_pkg::UNIT_W-1:0] o_z_unit,
    output logic [vn3d_pkg::MAG_W-1:0]        o_magnitude,
    output logic                              o_zero_vector
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int FB = UNIT_FRACTION_BITS;
    localparam int ND = FB + 1;

    logic en;

    vn3d_pkg::t_flags        r1_flags, r2_flags, r3_flags;
    logic [2:0][CW-1:0]      r1_abs, r2_abs, r3_abs;
    logic [2:0][2*CW-1:0]    r2_sq;
    logic [2*CW-1:0]         r3_sum;
    logic [2:0][CW-1:0]      n_abs;

    vn3d_pkg::t_flags        s_flags [0:CW];
    logic [2*CW-1:0]         s_rad   [0:CW];
    logic [CW+1:0]           s_rem   [0:CW];
    logic [CW-1:0]           s_root  [0:CW];
    logic [3*CW-1:0]         s_side  [0:CW];

    vn3d_pkg::t_flags        d_flags [0:ND];
    logic [CW-1:0]           d_mag   [0:ND];
    logic [2:0][CW:0]        d_rem   [0:ND];
    logic [2:0][FB:0]        d_q     [0:ND];

    logic [2:0][FB+1:0]      sgn_q;
    logic                    last_neg [3];
    logic                    zero;

    assign en      = !(d_flags[ND].valid && i_stall);
    assign o_stall = !en;

    assign n_abs[0] = i_x_in[CW-1] ? (CW'(0) - i_x_in) : i_x_in;
    assign n_abs[1] = i_y_in[CW-1] ? (CW'(0) - i_y_in) : i_y_in;
    assign n_abs[2] = i_z_in[CW-1] ? (CW'(0) - i_z_in) : i_z_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_flags.valid <= 1'b0;
            r2_flags.valid <= 1'b0;
            r3_flags.valid <= 1'b0;
        end else if (en) begin
            r1_flags.valid <= i_valid;
            r2_flags.valid <= r1_flags.valid;
            r3_flags.valid <= r2_flags.valid;
        end
        if (en) begin
            r1_flags.neg_x <= i_x_in[CW-1];
            r1_flags.neg_y <= i_y_in[CW-1];
            r1_flags.neg_z <= i_z_in[CW-1];
            r1_abs         <= n_abs;
            r2_flags.neg_x <= r1_flags.neg_x;
            r2_flags.neg_y <= r1_flags.neg_y;
            r2_flags.neg_z <= r1_flags.neg_z;
            r2_abs         <= r1_abs;
            for (int k = 0; k < 3; k++) begin
                r2_sq[k] <= (2*CW)'(r1_abs[k]) * (2*CW)'(r1_abs[k]);
            end
            r3_flags.neg_x <= r2_flags.neg_x;
            r3_flags.neg_y <= r2_flags.neg_y;
            r3_flags.neg_z <= r2_flags.neg_z;
            r3_abs         <= r2_abs;
            r3_sum         <= r2_sq[0] + r2_sq[1] + r2_sq[2];
        end
    end

    assign s_flags[0] = r3_flags;
    assign s_rad[0]   = r3_sum;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = r3_abs;

    for (genvar g = 0; g < CW; g++) begin : g_sqrt
        vn3d_sqrt_cell #(
            .CW     (CW),
            .SIDE_W (3*CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_flags (s_flags[g]),
            .i_rad   (s_rad[g]),
            .i_rem   (s_rem[g]),
            .i_root  (s_root[g]),
            .i_side  (s_side[g]),
            .o_flags (s_flags[g+1]),
            .o_rad   (s_rad[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_root  (s_root[g+1]),
            .o_side  (s_side[g+1])
        );
    end

    assign d_flags[0] = s_flags[CW];
    assign d_mag[0]   = s_root[CW];
    assign d_q[0]     = '0;
    assign d_rem[0]   = {{1'b0, s_side[CW][2*CW +: CW]},
                         {1'b0, s_side[CW][CW +: CW]},
                         {1'b0, s_side[CW][0 +: CW]}};

    for (genvar g = 0; g < ND; g++) begin : g_div
        vn3d_div_cell #(
            .CW    (CW),
            .FB    (FB),
            .FIRST (g == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_flags (d_flags[g]),
            .i_mag   (d_mag[g]),
            .i_rem   (d_rem[g]),
            .i_q     (d_q[g]),
            .o_flags (d_flags[g+1]),
            .o_mag   (d_mag[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_q     (d_q[g+1])
        );
    end

    assign last_neg[0] = d_flags[ND].neg_x;
    assign last_neg[1] = d_flags[ND].neg_y;
    assign last_neg[2] = d_flags[ND].neg_z;
    assign zero        = (d_mag[ND] == '0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sgn_q[k] = last_neg[k] ? ((FB+2)'(0) - {1'b0, d_q[ND][k]})
                                   : {1'b0, d_q[ND][k]};
            if (zero) begin
                sgn_q[k] = '0;
            end
        end
    end

    assign o_valid       = d_flags[ND].valid;
    assign o_x_unit      = vn3d_pkg::UNIT_W'(signed'(sgn_q[0]));
    assign o_y_unit      = vn3d_pkg::UNIT_W'(signed'(sgn_q[1]));
    assign o_z_unit      = vn3d_pkg::UNIT_W'(signed'(sgn_q[2]));
    assign o_magnitude   = vn3d_pkg::MAG_W'(d_mag[ND]);
    assign o_zero_vector = zero;

endmodule

// ----- rtl/vn3d_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// vn3d_sqrt_cell
// One digit of the integer square root: takes two radicand bits, settles one
// root bit and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module vn3d_sqrt_cell #(
    parameter int CW     = 16,
    parameter int SIDE_W = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  vn3d_pkg::t_flags      i_flags,
    input  logic [2*CW-1:0]       i_rad,
    input  logic [CW+1:0]         i_rem,
    input  logic [CW-1:0]         i_root,
    input  logic [SIDE_W-1:0]     i_side,
    output vn3d_pkg::t_flags      o_flags,
    output logic [2*CW-1:0]       o_rad,
    output logic [CW+1:0]         o_rem,
    output logic [CW-1:0]         o_root,
    output logic [SIDE_W-1:0]     o_side
);

    logic [CW+1:0] rem_sh;
    logic [CW+1:0] trial;
    logic          ge;

    vn3d_pkg::t_flags    r_flags;
    logic [2*CW-1:0]     r_rad;
    logic [CW+1:0]       r_rem;
    logic [CW-1:0]       r_root;
    logic [SIDE_W-1:0]   r_side;

    assign rem_sh = {i_rem[CW-1:0], i_rad[2*CW-1 -: 2]};
    assign trial  = {i_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.valid <= 1'b0;
        end else if (i_en) begin
            r_flags.valid <= i_flags.valid;
        end
        if (i_en) begin
            r_flags.neg_x <= i_flags.neg_x;
            r_flags.neg_y <= i_flags.neg_y;
            r_flags.neg_z <= i_flags.neg_z;
            r_rad         <= {i_rad[2*CW-3:0], 2'b00};
            r_rem         <= ge ? (rem_sh - trial) : rem_sh;
            r_root        <= {i_root[CW-2:0], ge};
            r_side        <= i_side;
        end
    end

    assign o_flags = r_flags;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// ----- rtl/vn3d_div_cell.sv -----
// ----------------------------------------------------------------------------
// vn3d_div_cell
// One quotient bit for each of the three components, divided by the length
// with a restoring step.
// ----------------------------------------------------------------------------
module vn3d_div_cell #(
    parameter int CW    = 16,
    parameter int FB    = 14,
    parameter bit FIRST = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  vn3d_pkg::t_flags      i_flags,
    input  logic [CW-1:0]         i_mag,
    input  logic [2:0][CW:0]      i_rem,
    input  logic [2:0][FB:0]      i_q,
    output vn3d_pkg::t_flags      o_flags,
    output logic [CW-1:0]         o_mag,
    output logic [2:0][CW:0]      o_rem,
    output logic [2:0][FB:0]      o_q
);

    logic [2:0][CW:0] rs;
    logic [2:0]       ge;
    logic [2:0][CW:0] n_rem;
    logic [2:0][FB:0] n_q;

    vn3d_pkg::t_flags r_flags;
    logic [CW-1:0]    r_mag;
    logic [2:0][CW:0] r_rem;
    logic [2:0][FB:0] r_q;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rs[k]    = FIRST ? i_rem[k] : {i_rem[k][CW-1:0], 1'b0};
            ge[k]    = (rs[k] >= {1'b0, i_mag});
            n_rem[k] = ge[k] ? (rs[k] - {1'b0, i_mag}) : rs[k];
            n_q[k]   = {i_q[k][FB-1:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.valid <= 1'b0;
        end else if (i_en) begin
            r_flags.valid <= i_flags.valid;
        end
        if (i_en) begin
            r_flags.neg_x <= i_flags.neg_x;
            r_flags.neg_y <= i_flags.neg_y;
            r_flags.neg_z <= i_flags.neg_z;
            r_mag         <= i_mag;
            r_rem         <= n_rem;
            r_q           <= n_q;
        end
    end

    assign o_flags = r_flags;
    assign o_mag   = r_mag;
    assign o_rem   = r_rem;
    assign o_q     = r_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3d vector normalizer: a directed table of
// corner vectors, then random vectors under several idle and stall mixes,
// each result compared against an in-bench fixed-point normalizer.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW      = 16;
    localparam int FB      = 14;
    localparam int LATENCY = CW + FB + 4;
    localparam int LIMIT   = 400000;
    localparam int N_RAND  = 1500;

    typedef struct packed {
        logic signed [15:0] x_unit;
        logic signed [15:0] y_unit;
        logic signed [15:0] z_unit;
        logic [15:0]        magnitude;
        logic               zero_vector;
    } t_norm;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        bit                   typed;
        t_norm                res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [CW-1:0] i_x_in = '0;
    logic signed [CW-1:0] i_y_in = '0;
    logic signed [CW-1:0] i_z_in = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [15:0]   o_x_unit;
    logic signed [15:0]   o_y_unit;
    logic signed [15:0]   o_z_unit;
    logic [15:0]          o_magnitude;
    logic                 o_zero_vector;

    t_norm  expected_norms[$];
    int     errors = 0;
    int     n_checked = 0;
    int     n_sent = 0;
    int     cycles = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    int     hold_cycles = 0;
    t_row   rows[$];

    vector_normalize_3d_top #(.COMPONENT_WIDTH(CW), .UNIT_FRACTION_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_x_in(i_x_in), .i_y_in(i_y_in), .i_z_in(i_z_in),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_x_unit(o_x_unit), .o_y_unit(o_y_unit), .o_z_unit(o_z_unit),
        .o_magnitude(o_magnitude), .o_zero_vector(o_zero_vector)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_comp(logic signed [CW-1:0] c, logic [63:0] mag);
        logic [63:0] a;
        logic [63:0] q;
        a = c[CW-1] ? 64'(-65'(c)) : 64'(c);
        q = (a << FB) / mag;
        if (c[CW-1]) q = -q;
        return q[15:0];
    endfunction

    function automatic t_norm normalize(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z);
        t_norm r;
        logic [63:0] sum;
        logic [63:0] mag;
        sum = 64'($signed(64'(x)) * $signed(64'(x))) + 64'($signed(64'(y)) * $signed(64'(y)))
            + 64'($signed(64'(z)) * $signed(64'(z)));
        mag = floor_sqrt(sum);
        r = '0;
        if (mag == 0) begin
            r.zero_vector = 1'b1;
        end else begin
            r.x_unit = unit_comp(x, mag);
            r.y_unit = unit_comp(y, mag);
            r.z_unit = unit_comp(z, mag);
            r.magnitude = mag[15:0];
        end
        return r;
    endfunction

    function automatic t_row mk(int x, int y, int z, bit typed = 0, int ux = 0, int uy = 0,
                                int uz = 0, int m = 0, bit zv = 0);
        t_row r;
        r.x = CW'(x); r.y = CW'(y); r.z = CW'(z); r.typed = typed;
        r.res.x_unit = 16'(ux); r.res.y_unit = 16'(uy); r.res.z_unit = 16'(uz);
        r.res.magnitude = 16'(m); r.res.zero_vector = zv;
        return r;
    endfunction

    task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_x_in <= x;
        i_y_in <= y;
        i_z_in <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_norms.size() != 0) @(negedge i_clk);
    endtask

    // record expectation on each accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_norms.push_back(normalize(i_x_in, i_y_in, i_z_in));
        end
    end

    // check each accepted output beat
    always @(posedge i_clk) begin
        t_norm got;
        t_norm want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_x_unit, o_y_unit, o_z_unit, o_magnitude, o_zero_vector};
            if (expected_norms.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, got);
                errors++;
            end else begin
                want = expected_norms.pop_front();
                n_checked++;
                if (got.x_unit !== want.x_unit)
                    $display("%0t: x_unit exp %0d got %0d", $time, want.x_unit, got.x_unit);
                if (got.y_unit !== want.y_unit)
                    $display("%0t: y_unit exp %0d got %0d", $time, want.y_unit, got.y_unit);
                if (got.z_unit !== want.z_unit)
                    $display("%0t: z_unit exp %0d got %0d", $time, want.z_unit, got.z_unit);
                if (got.magnitude !== want.magnitude)
                    $display("%0t: magnitude exp %0d got %0d", $time, want.magnitude,
                             got.magnitude);
                if (got.zero_vector !== want.zero_vector)
                    $display("%0t: zero_vector exp %0b got %0b", $time, want.zero_vector,
                             got.zero_vector);
                if (got !== want) errors++;
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(5, 0))
            0:       return CW'(int'($urandom_range(3, 0)) - 2);
            1:       return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
            2:       return CW'(int'($urandom_range(255, 0)) - 128);
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        t_row r;
        logic signed [CW-1:0] vx, vy, vz;
        rows.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0, 1));
        rows.push_back(mk(1, 1, 0, 1, 16384, 16384, 0, 1, 0));
        rows.push_back(mk(1, 0, 0, 1, 16384, 0, 0, 1, 0));
        rows.push_back(mk(0, -1, 0, 1, 0, -16384, 0, 1, 0));
        rows.push_back(mk(0, 0, 32767, 1, 0, 0, 16384, 32767, 0));
        rows.push_back(mk(-32768, 0, 0, 1, -16384, 0, 0, 32768, 0));
        rows.push_back(mk(-1, -1, -1, 1, -16384, -16384, -16384, 1, 0));
        rows.push_back(mk(3, 4, 0, 1, 9830, 13107, 0, 5, 0));
        rows.push_back(mk(-32768, -32768, -32768));
        rows.push_back(mk(32767, 32767, 32767));
        rows.push_back(mk(32767, -32768, 32767));
        rows.push_back(mk(-32768, 32767, -32768));
        rows.push_back(mk(1, 2, 2));
        rows.push_back(mk(0, 0, -32768));
        rows.push_back(mk(21845, -10922, 5461));
        rows.push_back(mk(-21846, 10921, -5462));
        rows.push_back(mk(100, -200, 300));
        rows.push_back(mk(0, 1, 1));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            if (r.typed && normalize(r.x, r.y, r.z) !== r.res) begin
                $display("%0t: table row %0d exp %p model %p", $time, k, r.res,
                         normalize(r.x, r.y, r.z));
                errors++;
            end
            send_vector(r.x, r.y, r.z);
        end
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 73; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 73; end
                3: begin send_idle_pct = 13; stall_pct = 13; end
                default: begin send_idle_pct = 0; stall_pct = 0; hold_cycles = 200; end
            endcase
            for (int k = 0; k < N_RAND / 5; k++) begin
                vx = rand_comp();
                vy = rand_comp();
                vz = rand_comp();
                send_vector(vx, vy, vz);
            end
            // sender pauses until every expected result has come
            drain();
        end

        stall_pct = 0;
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("covered %0d input beats and %0d checked results over idle, stall and",
                 n_sent, n_checked);
        $display("long hold-off phases, including zero, unit and full-scale vectors");
        if (errors == 0 && expected_norms.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
